### rtl/bmp_pkg.sv
// ----------------------------------------------------------------------------
// bmp_pkg: shared constants for the binomial coefficient block
// Default widths, reset value of the modulus and register-port constants.
// ----------------------------------------------------------------------------
package bmp_pkg;

	localparam int N_BITS_DEF = 16;
	localparam int P_BITS_DEF = 32;
	localparam int VALUE_W = 32;
	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;
	localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
	localparam logic [31:0] FERMAT_EXP_OFFSET = 32'd2;
	localparam logic REG_MODULUS = 1'b0;

endpackage

### rtl/bmp_in_if.sv
// ----------------------------------------------------------------------------
// bmp_in_if: input channel
// Carries one (top, choose) pair per transaction with valid and ready.
// ----------------------------------------------------------------------------
interface bmp_in_if #(
	parameter int N_BITS = bmp_pkg::N_BITS_DEF
);
	logic              valid;
	logic              ready;
	logic [N_BITS-1:0] top;
	logic [N_BITS-1:0] choose;

	modport source (output valid, output top, output choose, input ready);
	modport sink (input valid, input top, input choose, output ready);
endinterface

### rtl/bmp_out_if.sv
// ----------------------------------------------------------------------------
// bmp_out_if: result channel
// Carries one (value, range_error) pair per transaction with valid and ready.
// ----------------------------------------------------------------------------
interface bmp_out_if;
	logic                        valid;
	logic                        ready;
	logic [bmp_pkg::VALUE_W-1:0] value;
	logic                        range_error;

	modport source (output valid, output value, output range_error, input ready);
	modport sink (input valid, input value, input range_error, output ready);
endinterface

### rtl/bmp_mulmod.sv
// ----------------------------------------------------------------------------
// bmp_mulmod: shared modular multiplier
// Registers a*b, then reduces the product by the modulus with a restoring
// remainder that consumes two product bits per cycle.
// ----------------------------------------------------------------------------
module bmp_mulmod #(
	parameter int P_BITS = bmp_pkg::P_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [P_BITS-1:0] a,
	input  logic [P_BITS-1:0] b,
	input  logic [P_BITS-1:0] modulus,
	output logic              done,
	output logic [P_BITS-1:0] result
);
	localparam int PW = 2 * P_BITS;
	localparam int CW = $clog2(P_BITS);

	typedef enum logic {MM_IDLE, MM_REDUCE} mm_state_t;

	mm_state_t         state_q;
	logic [PW-1:0]     prod_q;
	logic [P_BITS-1:0] rem_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q;
	logic [P_BITS-1:0] rem_mid;
	logic [P_BITS-1:0] rem_next;

	function automatic logic [P_BITS-1:0] rem_step(input logic [P_BITS-1:0] rem,
		input logic bit_in, input logic [P_BITS-1:0] p);
		logic [P_BITS:0] t;
		t = {rem, bit_in};
		if (t >= {1'b0, p}) begin
			t = t - {1'b0, p};
		end
		return t[P_BITS-1:0];
	endfunction

	assign rem_mid  = rem_step(rem_q, prod_q[PW-1], modulus);
	assign rem_next = rem_step(rem_mid, prod_q[PW-2], modulus);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			rem_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				MM_IDLE: begin
					if (start) begin
						prod_q  <= PW'(a) * PW'(b);
						rem_q   <= '0;
						cnt_q   <= CW'(P_BITS - 1);
						state_q <= MM_REDUCE;
					end
				end
				MM_REDUCE: begin
					prod_q <= prod_q << 2;
					rem_q  <= rem_next;
					cnt_q  <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						done_q  <= 1'b1;
						state_q <= MM_IDLE;
					end
				end
				default: state_q <= MM_IDLE;
			endcase
		end
	end

	assign done   = done_q;
	assign result = rem_q;
endmodule

### rtl/bmp_ctrl.sv
// ----------------------------------------------------------------------------
// bmp_ctrl: sequencer and working registers
// Runs the factorial product, both Fermat inversions and the final products
// on the shared multiplier, and holds the result register.
// ----------------------------------------------------------------------------
module bmp_ctrl #(
	parameter int N_BITS = bmp_pkg::N_BITS_DEF,
	parameter int P_BITS = bmp_pkg::P_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [P_BITS-1:0] modulus,
	bmp_in_if.sink            items,
	bmp_out_if.source         results,
	output logic              mm_start,
	output logic [P_BITS-1:0] mm_a,
	output logic [P_BITS-1:0] mm_b,
	input  logic              mm_done,
	input  logic [P_BITS-1:0] mm_result
);
	typedef enum logic [2:0] {
		S_IDLE, S_FACT, S_FACT_W, S_EXP, S_ACC_W, S_SQR_W, S_FIN_W, S_RESULT
	} ctrl_state_t;

	ctrl_state_t       state_q;
	logic [N_BITS-1:0] n_q;
	logic [N_BITS-1:0] r_q;
	logic [N_BITS-1:0] rest_q;
	logic [N_BITS-1:0] idx_q;
	logic [P_BITS-1:0] idx_mod_q;
	logic [P_BITS-1:0] fact_q;
	logic [P_BITS-1:0] fact_choose_q;
	logic [P_BITS-1:0] fact_rest_q;
	logic [P_BITS-1:0] base_q;
	logic [P_BITS-1:0] exp_q;
	logic [P_BITS-1:0] acc_q;
	logic [P_BITS-1:0] res_q;
	logic              err_q;
	logic              second_q;
	logic              mm_start_q;
	logic [P_BITS-1:0] mm_a_q;
	logic [P_BITS-1:0] mm_b_q;
	logic              out_valid_q;
	logic [bmp_pkg::VALUE_W-1:0] out_value_q;
	logic              out_err_q;
	logic [P_BITS:0]   idx_mod_inc;
	logic [P_BITS-1:0] idx_mod_next;
	logic [P_BITS-1:0] fermat_exp;

	assign idx_mod_inc  = {1'b0, idx_mod_q} + 1'b1;
	assign idx_mod_next = (idx_mod_inc == {1'b0, modulus}) ? '0 : idx_mod_inc[P_BITS-1:0];
	assign fermat_exp   = modulus - P_BITS'(bmp_pkg::FERMAT_EXP_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mm_start_q  <= 1'b0;
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
			idx_q       <= '0;
			fact_q      <= P_BITS'(1);
			fact_choose_q <= '0;
			fact_rest_q <= '0;
			base_q      <= '0;
			exp_q       <= '0;
			acc_q       <= P_BITS'(1);
		end else begin
			mm_start_q <= 1'b0;
			if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (items.valid) begin
						n_q       <= items.top;
						r_q       <= items.choose;
						rest_q    <= items.top - items.choose;
						idx_q     <= '0;
						idx_mod_q <= '0;
						fact_q    <= P_BITS'(1);
						fact_choose_q <= P_BITS'(1);
						fact_rest_q   <= P_BITS'(1);
						err_q     <= 1'b0;
						res_q     <= '0;
						if (items.choose == '0) begin
							res_q   <= P_BITS'(1);
							state_q <= S_RESULT;
						end else if (items.choose > items.top) begin
							err_q   <= 1'b1;
							state_q <= S_RESULT;
						end else if (modulus < P_BITS'(2)) begin
							state_q <= S_RESULT;
						end else begin
							state_q <= S_FACT;
						end
					end
				end
				S_FACT: begin
					if (idx_q == n_q) begin
						res_q    <= fact_q;
						base_q   <= fact_choose_q;
						exp_q    <= fermat_exp;
						acc_q    <= P_BITS'(1);
						second_q <= 1'b0;
						state_q  <= S_EXP;
					end else begin
						idx_q      <= idx_q + 1'b1;
						idx_mod_q  <= idx_mod_next;
						mm_a_q     <= fact_q;
						mm_b_q     <= idx_mod_next;
						mm_start_q <= 1'b1;
						state_q    <= S_FACT_W;
					end
				end
				S_FACT_W: begin
					if (mm_done) begin
						fact_q <= mm_result;
						if (idx_q == r_q) begin
							fact_choose_q <= mm_result;
						end
						if (idx_q == rest_q) begin
							fact_rest_q <= mm_result;
						end
						state_q <= S_FACT;
					end
				end
				S_EXP: begin
					mm_start_q <= 1'b1;
					if (exp_q == '0) begin
						mm_a_q  <= res_q;
						mm_b_q  <= acc_q;
						state_q <= S_FIN_W;
					end else if (exp_q[0]) begin
						mm_a_q  <= acc_q;
						mm_b_q  <= base_q;
						state_q <= S_ACC_W;
					end else begin
						mm_a_q  <= base_q;
						mm_b_q  <= base_q;
						state_q <= S_SQR_W;
					end
				end
				S_ACC_W: begin
					if (mm_done) begin
						acc_q      <= mm_result;
						mm_a_q     <= base_q;
						mm_b_q     <= base_q;
						mm_start_q <= 1'b1;
						state_q    <= S_SQR_W;
					end
				end
				S_SQR_W: begin
					if (mm_done) begin
						base_q  <= mm_result;
						exp_q   <= exp_q >> 1;
						state_q <= S_EXP;
					end
				end
				S_FIN_W: begin
					if (mm_done) begin
						res_q <= mm_result;
						if (!second_q) begin
							base_q   <= fact_rest_q;
							exp_q    <= fermat_exp;
							acc_q    <= P_BITS'(1);
							second_q <= 1'b1;
							state_q  <= S_EXP;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_RESULT: begin
					if (!out_valid_q || results.ready) begin
						out_value_q <= bmp_pkg::VALUE_W'(res_q);
						out_err_q   <= err_q;
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign items.ready         = (state_q == S_IDLE);
	assign results.valid       = out_valid_q;
	assign results.value       = out_value_q;
	assign results.range_error = out_err_q;
	assign mm_start            = mm_start_q;
	assign mm_a                = mm_a_q;
	assign mm_b                = mm_b_q;
endmodule

### rtl/binomial_mod_prime.sv
// ----------------------------------------------------------------------------
// binomial_mod_prime: binomial coefficient modulo a prime
// Returns C(top, choose) mod the configured modulus for each transaction.
// ----------------------------------------------------------------------------
// Each transaction is worked by one shared modular multiplier. The block
// forms top! with top products, then inverts choose! and (top-choose)! by
// square-and-multiply to the power modulus-2, up to 2*P_BITS products
// each, and two more products finish the result. A choose of zero, a
// choose above top (range_error set, value 0) or a modulus below two
// (value 0) answers without using the multiplier. The input channel is not
// ready while a transaction is being worked; the result register lets the
// next transaction start before the previous result is taken. The modulus
// sits at APB byte address 0 and should only be written while the block is
// idle.
// ----------------------------------------------------------------------------
module binomial_mod_prime #(
	parameter int N_BITS = bmp_pkg::N_BITS_DEF,
	parameter int P_BITS = bmp_pkg::P_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bmp_in_if.sink                         items,
	bmp_out_if.source                      results,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bmp_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [bmp_pkg::APB_DATA_W-1:0] pwdata,
	output logic [bmp_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready
);
	logic [P_BITS-1:0] modulus_q;
	logic              mm_start;
	logic [P_BITS-1:0] mm_a;
	logic [P_BITS-1:0] mm_b;
	logic              mm_done;
	logic [P_BITS-1:0] mm_result;
	logic              reg_hit;

	assign reg_hit = (paddr[bmp_pkg::APB_ADDR_W-1] == bmp_pkg::REG_MODULUS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= P_BITS'(bmp_pkg::MODULUS_RESET);
		end else if (psel && penable && pwrite && reg_hit) begin
			modulus_q <= pwdata[P_BITS-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = reg_hit ? bmp_pkg::APB_DATA_W'(modulus_q) : '0;

	bmp_ctrl #(
		.N_BITS(N_BITS),
		.P_BITS(P_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.modulus  (modulus_q),
		.items    (items),
		.results  (results),
		.mm_start (mm_start),
		.mm_a     (mm_a),
		.mm_b     (mm_b),
		.mm_done  (mm_done),
		.mm_result(mm_result)
	);

	bmp_mulmod #(
		.P_BITS(P_BITS)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mm_start),
		.a      (mm_a),
		.b      (mm_b),
		.modulus(modulus_q),
		.done   (mm_done),
		.result (mm_result)
	);
endmodule
